>>> src/gda_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and calendar tables for the gregorian date unit
// no dependencies; used by every module of the block

package gda_pkg;

	localparam int YEAR_LIMIT = 16383;

	// day count of the years 0 .. YEAR_LIMIT, the last valid ordinal day
	localparam int YL1       = YEAR_LIMIT + 1;
	localparam int DBY_LIMIT = YL1 * 365 + (YL1 + 3) / 4 - (YL1 + 99) / 100 + (YL1 + 399) / 400;

	// reciprocal constants: q100 = (x * R100) >> 19, q400 = (x * R100) >> 21
	localparam logic [12:0] RECIP100  = 13'd5243;
	// year estimate: y ~ (n * RECIP_YR) >> 30, corrected by the year walks
	localparam logic [21:0] RECIP_YR  = 22'd2939805;
	// exact floor(x / 7) for x below 2^23: (x * RECIP7) >> 29
	localparam logic [26:0] RECIP7    = 27'd76695845;

	// datapath operations
	localparam logic [4:0] OP_NONE   = 5'd0;
	localparam logic [4:0] OP_LOAD   = 5'd1;
	localparam logic [4:0] OP_DBY_A  = 5'd2;
	localparam logic [4:0] OP_ORD_A  = 5'd3;
	localparam logic [4:0] OP_DBY_B  = 5'd4;
	localparam logic [4:0] OP_DIFF   = 5'd5;
	localparam logic [4:0] OP_DBY_YA = 5'd6;
	localparam logic [4:0] OP_DOY    = 5'd7;
	localparam logic [4:0] OP_W_MUL  = 5'd8;
	localparam logic [4:0] OP_W_FIN  = 5'd9;
	localparam logic [4:0] OP_SUM    = 5'd10;
	localparam logic [4:0] OP_EST    = 5'd11;
	localparam logic [4:0] OP_DBY_Y  = 5'd12;
	localparam logic [4:0] OP_DOWN   = 5'd13;
	localparam logic [4:0] OP_DBY_U  = 5'd14;
	localparam logic [4:0] OP_UP     = 5'd15;
	localparam logic [4:0] OP_MONTH  = 5'd16;

	// request codes
	localparam logic [1:0] REQ_DIFF = 2'd0;
	localparam logic [1:0] REQ_ADD  = 2'd1;
	localparam logic [1:0] REQ_WDAY = 2'd2;
	localparam logic [1:0] REQ_DOY  = 2'd3;

	typedef struct packed {
		logic [4:0] op;
		logic       commit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       bad;
		logic       down;
		logic       up;
		logic       mstep;
	} status_t;

	localparam logic [8:0] CUM_DAYS [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
	localparam logic [4:0] MONTH_DAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	// days before month m (1..12) of a year
	function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
		logic [3:0] idx;
		logic [8:0] s;
		idx = m - 4'd1;
		s = (idx < 4'd12) ? CUM_DAYS[idx] : 9'd0;
		if (leap && m > 4'd2)
			s = s + 9'd1;
		return s;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [3:0] idx;
		logic [4:0] l;
		idx = m - 4'd1;
		l = (idx < 4'd12) ? MONTH_DAYS[idx] : 5'd31;
		if (leap && m == 4'd2)
			l = 5'd29;
		return l;
	endfunction

endpackage

>>> src/gda_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the gregorian date unit
// depends on gda_pkg; drives gda_datapath through cmd_t and reads status_t

module gda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output gda_pkg::cmd_t     cmd,
	input  gda_pkg::status_t  st
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_OA1  = 4'd1;
	localparam logic [3:0] S_OA2  = 4'd2;
	localparam logic [3:0] S_OB1  = 4'd3;
	localparam logic [3:0] S_DIFF = 4'd4;
	localparam logic [3:0] S_YA1  = 4'd5;
	localparam logic [3:0] S_DOY  = 4'd6;
	localparam logic [3:0] S_W1   = 4'd7;
	localparam logic [3:0] S_W2   = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;
	localparam logic [3:0] S_EST  = 4'd10;
	localparam logic [3:0] S_Y1   = 4'd11;
	localparam logic [3:0] S_Y2   = 4'd12;
	localparam logic [3:0] S_U1   = 4'd13;
	localparam logic [3:0] S_U2   = 4'd14;
	localparam logic [3:0] S_MON  = 4'd15;

	logic [3:0] state_q, state_d;
	logic       done_q;

	always_comb begin
		state_d    = state_q;
		cmd.op     = gda_pkg::OP_NONE;
		cmd.commit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = gda_pkg::OP_LOAD;
					state_d = S_OA1;
				end
			end
			S_OA1: begin
				cmd.op  = gda_pkg::OP_DBY_A;
				state_d = S_OA2;
			end
			S_OA2: begin
				cmd.op = gda_pkg::OP_ORD_A;
				unique case (st.req)
					gda_pkg::REQ_DIFF: state_d = S_OB1;
					gda_pkg::REQ_ADD:  state_d = S_SUM;
					gda_pkg::REQ_WDAY: state_d = S_W1;
					default:           state_d = S_YA1;
				endcase
			end
			S_OB1: begin
				cmd.op  = gda_pkg::OP_DBY_B;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				cmd.op     = gda_pkg::OP_DIFF;
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			S_YA1: begin
				cmd.op  = gda_pkg::OP_DBY_YA;
				state_d = S_DOY;
			end
			S_DOY: begin
				cmd.op     = gda_pkg::OP_DOY;
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			S_W1: begin
				cmd.op  = gda_pkg::OP_W_MUL;
				state_d = S_W2;
			end
			S_W2: begin
				cmd.op     = gda_pkg::OP_W_FIN;
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			S_SUM: begin
				cmd.op = gda_pkg::OP_SUM;
				if (st.bad) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end else begin
					state_d = S_EST;
				end
			end
			S_EST: begin
				cmd.op  = gda_pkg::OP_EST;
				state_d = S_Y1;
			end
			S_Y1: begin
				cmd.op  = gda_pkg::OP_DBY_Y;
				state_d = S_Y2;
			end
			S_Y2: begin
				cmd.op  = gda_pkg::OP_DOWN;
				state_d = st.down ? S_Y1 : S_U1;
			end
			S_U1: begin
				cmd.op  = gda_pkg::OP_DBY_U;
				state_d = S_U2;
			end
			S_U2: begin
				cmd.op  = gda_pkg::OP_UP;
				state_d = st.up ? S_U1 : S_MON;
			end
			S_MON: begin
				cmd.op = gda_pkg::OP_MONTH;
				if (!st.mstep) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.commit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

>>> src/gda_datapath.sv
`timescale 1ns / 1ps
// datapath of the gregorian date unit: operand registers, day count unit,
// year and month walk registers, result registers; depends on gda_pkg

module gda_datapath (
	input  logic                clk,
	input  gda_pkg::cmd_t       cmd,
	output gda_pkg::status_t    st,
	input  logic [1:0]          req_type,
	input  logic [13:0]         year_a,
	input  logic [3:0]          month_a,
	input  logic [4:0]          day_a,
	input  logic [13:0]         year_b,
	input  logic [3:0]          month_b,
	input  logic [4:0]          day_b,
	input  logic signed [23:0]  day_offset,
	output logic signed [23:0]  number_out,
	output logic [13:0]         year_out,
	output logic [3:0]          month_out,
	output logic [4:0]          day_out,
	output logic                range_error
);

	logic [1:0]         req_q;
	logic [13:0]        ya_q, yb_q;
	logic [3:0]         ma_q, mb_q;
	logic [4:0]         da_q, db_q;
	logic signed [23:0] off_q;

	logic [14:0]        y_s1;
	logic [7:0]         q100_s1;
	logic [5:0]         q400_s1;

	logic signed [25:0] oa_q;
	logic [22:0]        n_q;
	logic [14:0]        y_q;
	logic [23:0]        dbyy_q;
	logic               leap_q;
	logic [8:0]         r_q;
	logic [3:0]         m_q;
	logic [19:0]        q7_q;

	// day count unit, first half: quotients by reciprocal multiply
	logic [14:0] ysel;
	logic [29:0] p100, p400;

	always_comb begin
		case (cmd.op)
			gda_pkg::OP_DBY_A:  ysel = 15'(ya_q) + ((ma_q > 4'd12) ? 15'd1 : 15'd0);
			gda_pkg::OP_DBY_B:  ysel = 15'(yb_q) + ((mb_q > 4'd12) ? 15'd1 : 15'd0);
			gda_pkg::OP_DBY_YA: ysel = 15'(ya_q);
			gda_pkg::OP_DBY_U:  ysel = y_q + 15'd1;
			default:            ysel = y_q;
		endcase
	end

	assign p100 = 30'(17'(ysel) + 17'd99) * 30'(gda_pkg::RECIP100);
	assign p400 = 30'(17'(ysel) + 17'd399) * 30'(gda_pkg::RECIP100);

	always_ff @(posedge clk) begin
		y_s1    <= ysel;
		q100_s1 <= 8'(p100 >> 19);
		q400_s1 <= 6'(p400 >> 21);
	end

	// second half: day count before the year, and its leap flag
	logic [23:0] dby2;
	logic        leap2;

	assign dby2 = 24'(24'(y_s1) * 24'd365) + 24'((16'(y_s1) + 16'd3) >> 2)
		- 24'(q100_s1) + 24'(q400_s1);
	assign leap2 = (y_s1[1:0] == 2'b00)
		&& ((16'(q100_s1) * 16'd100 != 16'(y_s1)) || (16'(q400_s1) * 16'd400 == 16'(y_s1)));

	// ordinal day of the date whose year is in the day count unit
	logic [3:0]         msel, madj;
	logic [4:0]         dsel;
	logic signed [25:0] ord2;

	always_comb begin
		msel = (cmd.op == gda_pkg::OP_DIFF) ? mb_q : ma_q;
		dsel = (cmd.op == gda_pkg::OP_DIFF) ? db_q : da_q;
		madj = (msel > 4'd12) ? msel - 4'd12 : msel;
		if (msel == 4'd0)
			ord2 = $signed(26'(dby2)) + $signed(26'(dsel)) - 26'sd31;
		else
			ord2 = $signed(26'(dby2)) + $signed(26'(gda_pkg::days_before_month(madj, leap2)))
				+ $signed(26'(dsel));
	end

	// add request: target day, range check, year estimate
	logic signed [25:0] t_sum;
	logic               bad;
	logic [44:0]        p_est;

	assign t_sum = oa_q + 26'(off_q);
	assign bad   = (t_sum < 26'sd1) || (t_sum > $signed(26'(gda_pkg::DBY_LIMIT)));
	assign p_est = 45'(n_q) * 45'(gda_pkg::RECIP_YR);

	// weekday: mod 7 of a shifted, nonnegative ordinal
	logic [22:0] wx;
	logic [49:0] p7;
	logic [2:0]  r7;

	assign wx = 23'(oa_q + 26'sd39);
	assign p7 = 50'(wx) * 50'(gda_pkg::RECIP7);
	assign r7 = 3'(wx - 23'(q7_q) * 23'd7);

	// month walk
	logic [4:0] mlen;
	assign mlen = gda_pkg::month_len(m_q, leap_q);

	assign st.req   = req_q;
	assign st.bad   = bad;
	assign st.down  = (y_q != 15'd0) && (dby2 > 24'(n_q));
	assign st.up    = (dby2 <= 24'(n_q));
	assign st.mstep = (m_q < 4'd12) && (r_q >= 9'(mlen));

	always_ff @(posedge clk) begin
		case (cmd.op)
			gda_pkg::OP_LOAD: begin
				req_q <= req_type;
				ya_q  <= year_a;
				ma_q  <= month_a;
				da_q  <= day_a;
				yb_q  <= year_b;
				mb_q  <= month_b;
				db_q  <= day_b;
				off_q <= day_offset;
			end
			gda_pkg::OP_ORD_A: oa_q <= ord2;
			gda_pkg::OP_W_MUL: q7_q <= 20'(p7 >> 29);
			gda_pkg::OP_SUM:   n_q <= 23'(t_sum - 26'sd1);
			gda_pkg::OP_EST:   y_q <= 15'(p_est >> 30);
			gda_pkg::OP_DOWN: begin
				if (st.down) begin
					y_q <= y_q - 15'd1;
				end else begin
					dbyy_q <= dby2;
					leap_q <= leap2;
				end
			end
			gda_pkg::OP_UP: begin
				if (st.up) begin
					y_q    <= y_q + 15'd1;
					dbyy_q <= dby2;
					leap_q <= leap2;
				end else begin
					r_q <= 9'(24'(n_q) - dbyy_q);
					m_q <= 4'd1;
				end
			end
			gda_pkg::OP_MONTH: begin
				if (st.mstep) begin
					r_q <= r_q - 9'(mlen);
					m_q <= m_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// result values selected by the finishing operation
	logic signed [23:0] num_d;
	logic [13:0]        yr_d;
	logic [3:0]         mo_d;
	logic [4:0]         dy_d;
	logic               err_d;

	always_comb begin
		num_d = '0;
		yr_d  = '0;
		mo_d  = '0;
		dy_d  = '0;
		err_d = 1'b0;
		case (cmd.op)
			gda_pkg::OP_DIFF:  num_d = 24'(oa_q - ord2);
			gda_pkg::OP_DOY:   num_d = 24'(oa_q - $signed(26'(dby2)));
			gda_pkg::OP_W_FIN: num_d = 24'(r7) + 24'sd1;
			gda_pkg::OP_SUM:   err_d = 1'b1;
			gda_pkg::OP_MONTH: begin
				yr_d = 14'(y_q);
				mo_d = m_q;
				dy_d = 5'(r_q + 9'd1);
			end
			default: ;
		endcase
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			number_out  <= num_d;
			year_out    <= yr_d;
			month_out   <= mo_d;
			day_out     <= dy_d;
			range_error <= err_d;
		end
	end

endmodule

>>> src/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// top level of the gregorian date unit
// depends on gda_pkg, gda_ctrl and gda_datapath

// A request is taken when start is high and busy is low; its single result
// appears in the cycle after the last work step, on the result ports with
// done high for exactly one cycle, and the receiver cannot stall it. An add
// whose sum is out of range ends at the sum step; otherwise the year walks
// pass each step through the shared day count unit (reciprocal multiply,
// then the day sum), and the month walk passes one month per cycle. One
// request is worked at a time; busy drops in the cycle the result shows, so
// the next transaction may start then.

module gregorian_date_arithmetic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [13:0]        year_a,
	input  logic [3:0]         month_a,
	input  logic [4:0]         day_a,
	input  logic [13:0]        year_b,
	input  logic [3:0]         month_b,
	input  logic [4:0]         day_b,
	input  logic signed [23:0] day_offset,
	output logic               done,
	output logic signed [23:0] number_out,
	output logic [13:0]        year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic               range_error
);

	// command and status between sequencer and datapath
	gda_pkg::cmd_t    cmd;
	gda_pkg::status_t st;

	gda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.st     (st)
	);

	gda_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.st          (st),
		.req_type    (req_type),
		.year_a      (year_a),
		.month_a     (month_a),
		.day_a       (day_a),
		.year_b      (year_b),
		.month_b     (month_b),
		.day_b       (day_b),
		.day_offset  (day_offset),
		.number_out  (number_out),
		.year_out    (year_out),
		.month_out   (month_out),
		.day_out     (day_out),
		.range_error (range_error)
	);

endmodule

>>> src/gda_checker.sv
`timescale 1ns / 1ps
// port level checks of the gregorian date unit, bound to the top level
// depends on gregorian_date_arithmetic

module gda_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [23:0] number_out,
	input logic [13:0]        year_out,
	input logic [3:0]         month_out,
	input logic [4:0]         day_out,
	input logic               range_error
);

	// an accepted transaction keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not raise busy");

	// a result only shows once the work is over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	// every finished transaction gives a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("work ended without a result");

	// an out of range sum carries no date
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && range_error |-> number_out == 24'sd0 && year_out == 14'd0
			&& month_out == 4'd0 && day_out == 5'd0)
		else $error("range error with nonzero fields");

	// a sum date has a real month and day
	a_date_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && month_out != 4'd0 |-> month_out <= 4'd12 && day_out != 5'd0)
		else $error("sum date out of calendar");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (.*);
